// ===== sv/priority_task_table_unit_assert.svh =====
// Assertion macros for the priority task table.
// Uses the clk and rst signals of the module that includes it.
`ifndef PRIORITY_TASK_TABLE_UNIT_ASSERT_SVH
`define PRIORITY_TASK_TABLE_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PTT_ASSERT_SAME(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("priority_task_table_unit: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define PTT_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("priority_task_table_unit: next-cycle check failed");

`endif

// ===== sv/ptt_pkg.sv =====
// Shared types, codes and helpers for the priority task table.
// No dependencies; used by ptt_entry_ram and priority_task_table_unit.
package ptt_pkg;

  localparam int TAG_W       = 16;
  localparam int PRIO_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_EXEC = 2'd1;
  localparam logic [1:0] FUNC_LIST = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

  typedef struct packed {
    logic              done;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] r;
    r = p;
    if (p < PRIO_MIN) r = PRIO_MIN;
    if (p > PRIO_MAX) r = PRIO_MAX;
    return r;
  endfunction

endpackage

// ===== sv/ptt_entry_ram.sv =====
// Entry memory of the task table: one write port and one registered read port.
// Depends on ptt_pkg for the entry layout.
module ptt_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ptt_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output ptt_pkg::entry_t  rdata
);

  ptt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/priority_task_table_unit.sv =====
// Top level of the priority task table: command sequencer and scan unit.
// Depends on ptt_pkg, ptt_entry_ram and priority_task_table_unit_assert.svh.
//
//   Channel  Handshake            Payload
//   command  start / busy         func, task_tag, task_priority
//   result   strobe (one cycle)   status, out_tag, out_priority, last
//
// An add's result is registered and appears in the cycle after the add is accepted.
// An execute or a list walks the entries, one per cycle, through the single read
// port of the entry memory; a list walks them once for each priority and stops
// early once it has found MAX_RESULTS entries.
// An empty table answers execute and list directly from the idle state, without a scan.
// Reset clears the entry count but not the memory; the memory needs no clearing pass.
// Results cannot be stalled and each is shown for exactly one cycle.
`include "priority_task_table_unit_assert.svh"

module priority_task_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] task_tag,
  input  logic [3:0]  task_priority,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [15:0] out_tag,
  output logic [3:0]  out_priority,
  output logic        last
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t                         state;
  logic                           is_list;
  logic [CNT_W-1:0]               entry_count;
  logic                           iss_on;
  logic [IDX_W-1:0]               iss_idx;
  logic [ptt_pkg::PRIO_W-1:0]     iss_pass;
  logic                           rd_vld;
  logic [IDX_W-1:0]               rd_idx;
  logic [ptt_pkg::PRIO_W-1:0]     rd_pass;
  logic                           best_found;
  logic [IDX_W-1:0]               best_idx;
  logic [ptt_pkg::PRIO_W-1:0]     best_prio;
  logic [ptt_pkg::TAG_W-1:0]      best_tag;
  logic                           pend_vld;
  logic [ptt_pkg::PRIO_W-1:0]     pend_prio;
  logic [ptt_pkg::TAG_W-1:0]      pend_tag;
  logic [ptt_pkg::N_W-1:0]        n_found;

  logic                           accept;
  logic                           has_room;
  logic [IDX_W-1:0]               last_idx;
  logic                           hit_exec;
  logic                           hit_list;
  logic                           list_full;
  logic                           we;
  logic [IDX_W-1:0]               waddr;
  ptt_pkg::entry_t                wdata;
  ptt_pkg::entry_t                rd_word;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign has_room  = (entry_count < CNT_W'(CAPACITY));
  assign last_idx  = IDX_W'(entry_count - CNT_W'(1));
  assign hit_exec  = rd_vld && !rd_word.done && (!best_found || (rd_word.prio < best_prio));
  assign hit_list  = rd_vld && !rd_word.done && (rd_word.prio == rd_pass);
  assign list_full = (n_found == ptt_pkg::N_W'(ptt_pkg::MAX_RESULTS - 1));

  always_comb begin
    we         = 1'b0;
    waddr      = entry_count[IDX_W-1:0];
    wdata.done = 1'b0;
    wdata.prio = ptt_pkg::clamp_prio(task_priority);
    wdata.tag  = task_tag;
    if (accept && (func == ptt_pkg::FUNC_ADD) && has_room) begin
      we = 1'b1;
    end else if ((state == S_FINISH) && !is_list && best_found) begin
      we         = 1'b1;
      waddr      = best_idx;
      wdata.done = 1'b1;
      wdata.prio = best_prio;
      wdata.tag  = best_tag;
    end
  end

  ptt_entry_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss_idx),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      is_list     <= 1'b0;
      strobe      <= 1'b0;
      entry_count <= '0;
      iss_on      <= 1'b0;
      rd_vld      <= 1'b0;
      best_found  <= 1'b0;
      pend_vld    <= 1'b0;
      n_found     <= '0;
    end else begin
      strobe  <= 1'b0;
      rd_vld  <= iss_on && (state == S_SCAN);
      rd_idx  <= iss_idx;
      rd_pass <= iss_pass;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              ptt_pkg::FUNC_ADD: begin
                strobe       <= 1'b1;
                last         <= 1'b1;
                out_tag      <= '0;
                out_priority <= '0;
                if (has_room) begin
                  status      <= ptt_pkg::STATUS_OK;
                  entry_count <= entry_count + CNT_W'(1);
                end else begin
                  status <= ptt_pkg::STATUS_FULL;
                end
              end
              ptt_pkg::FUNC_EXEC, ptt_pkg::FUNC_LIST: begin
                is_list    <= (func == ptt_pkg::FUNC_LIST);
                best_found <= 1'b0;
                pend_vld   <= 1'b0;
                n_found    <= '0;
                iss_idx    <= '0;
                iss_pass   <= ptt_pkg::PRIO_MIN;
                if (entry_count == '0) begin
                  strobe       <= 1'b1;
                  last         <= 1'b1;
                  status       <= ptt_pkg::STATUS_NONE;
                  out_tag      <= '0;
                  out_priority <= '0;
                end else begin
                  iss_on <= 1'b1;
                  state  <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (iss_on) begin
            if (iss_idx == last_idx) begin
              if (!is_list || (iss_pass == ptt_pkg::PRIO_MAX)) begin
                iss_on <= 1'b0;
              end else begin
                iss_idx  <= '0;
                iss_pass <= iss_pass + ptt_pkg::PRIO_W'(1);
              end
            end else begin
              iss_idx <= iss_idx + IDX_W'(1);
            end
          end
          if (!is_list && hit_exec) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_prio  <= rd_word.prio;
            best_tag   <= rd_word.tag;
          end
          if (is_list && hit_list) begin
            if (pend_vld) begin
              strobe       <= 1'b1;
              last         <= 1'b0;
              status       <= ptt_pkg::STATUS_OK;
              out_tag      <= pend_tag;
              out_priority <= pend_prio;
            end
            pend_vld  <= 1'b1;
            pend_tag  <= rd_word.tag;
            pend_prio <= rd_word.prio;
            n_found   <= n_found + ptt_pkg::N_W'(1);
          end
          if (is_list && hit_list && list_full) begin
            iss_on <= 1'b0;
            state  <= S_FINISH;
          end else if (!iss_on && !rd_vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          strobe <= 1'b1;
          last   <= 1'b1;
          state  <= S_IDLE;
          if (is_list ? pend_vld : best_found) begin
            status       <= ptt_pkg::STATUS_OK;
            out_tag      <= is_list ? pend_tag : best_tag;
            out_priority <= is_list ? pend_prio : best_prio;
          end else begin
            status       <= ptt_pkg::STATUS_NONE;
            out_tag      <= '0;
            out_priority <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PTT_ASSERT_SAME(a_count_range, 1'b1, entry_count <= CNT_W'(CAPACITY))
  `PTT_ASSERT_SAME(a_error_is_last, strobe && (status != ptt_pkg::STATUS_OK), last)
  `PTT_ASSERT_NEXT(a_finish_emits, state == S_FINISH, (state == S_IDLE) && strobe && last)
  `PTT_ASSERT_SAME(a_pass_range, iss_on, (iss_pass >= ptt_pkg::PRIO_MIN) && (iss_pass <= ptt_pkg::PRIO_MAX))
  `PTT_ASSERT_SAME(a_pending_counted, is_list && pend_vld && (state == S_SCAN), n_found != '0)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for priority_task_table_unit: random and directed commands
// are checked against a behavioural model of the task table held in this file.
// Depends on ptt_pkg and the priority_task_table_unit RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int TAG_W = ptt_pkg::TAG_W;
  localparam int PRIO_W = ptt_pkg::PRIO_W;
  localparam int MAX_RESULTS = ptt_pkg::MAX_RESULTS;
  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10 * TABLE_DEPTH + 40;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } command_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic              last;
  } table_outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        func = ptt_pkg::FUNC_ADD;
  logic [TAG_W-1:0]  task_tag = '0;
  logic [PRIO_W-1:0] task_priority = ptt_pkg::PRIO_MIN;
  logic              busy;
  logic              strobe;
  logic [1:0]        status;
  logic [TAG_W-1:0]  out_tag;
  logic [PRIO_W-1:0] out_priority;
  logic              last;

  command_t       pending_cmds[$];
  table_outcome_t expected_results[$];

  logic [TAG_W-1:0]  model_tags[TABLE_DEPTH];
  logic [PRIO_W-1:0] model_prios[TABLE_DEPTH];
  logic              model_done[TABLE_DEPTH];
  int                model_count = 0;

  logic took = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   items_total = 0;
  int   items_accepted = 0;
  int   error_count = 0;
  int   cycles_run = 0;

  priority_task_table_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .task_tag     (task_tag),
    .task_priority(task_priority),
    .strobe       (strobe),
    .status       (status),
    .out_tag      (out_tag),
    .out_priority (out_priority),
    .last         (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void queue_command(input logic [1:0] f, input logic [TAG_W-1:0] t,
                                        input logic [PRIO_W-1:0] p);
    command_t c;
    c.func = f;
    c.tag = t;
    c.prio = p;
    pending_cmds.insert(pending_cmds.size(), c);
    items_total++;
  endfunction

  function automatic logic [PRIO_W-1:0] random_prio();
    logic [PRIO_W-1:0] p;
    if ($urandom_range(0, 5) == 0) p = PRIO_W'($urandom_range(0, 15));
    else p = PRIO_W'($urandom_range(1, 10));
    return p;
  endfunction

  function automatic table_outcome_t make_outcome(input logic [1:0] s,
                                                 input logic [TAG_W-1:0] t,
                                                 input logic [PRIO_W-1:0] p,
                                                 input logic l);
    table_outcome_t o;
    o.status = s;
    o.tag = t;
    o.prio = p;
    o.last = l;
    return o;
  endfunction

  function automatic void queue_expected(input table_outcome_t o);
    expected_results.insert(expected_results.size(), o);
  endfunction

  task automatic predict_table_results(input command_t c);
    logic [PRIO_W-1:0] p;
    int                best;
    int                n;
    table_outcome_t    held;
    case (c.func)
      ptt_pkg::FUNC_ADD: begin
        if (model_count >= TABLE_DEPTH) begin
          queue_expected(make_outcome(ptt_pkg::STATUS_FULL, '0, '0, 1'b1));
        end else begin
          p = c.prio;
          if (p < ptt_pkg::PRIO_MIN) p = ptt_pkg::PRIO_MIN;
          if (p > ptt_pkg::PRIO_MAX) p = ptt_pkg::PRIO_MAX;
          model_tags[model_count] = c.tag;
          model_prios[model_count] = p;
          model_done[model_count] = 1'b0;
          model_count++;
          queue_expected(make_outcome(ptt_pkg::STATUS_OK, '0, '0, 1'b1));
        end
      end
      ptt_pkg::FUNC_EXEC: begin
        best = -1;
        for (int i = 0; i < model_count; i++) begin
          if (!model_done[i] && (best < 0 || model_prios[i] < model_prios[best])) best = i;
        end
        if (best < 0) begin
          queue_expected(make_outcome(ptt_pkg::STATUS_NONE, '0, '0, 1'b1));
        end else begin
          model_done[best] = 1'b1;
          queue_expected(make_outcome(ptt_pkg::STATUS_OK, model_tags[best],
                                      model_prios[best], 1'b1));
        end
      end
      ptt_pkg::FUNC_LIST: begin
        n = 0;
        held = '0;
        for (int q = ptt_pkg::PRIO_MIN; q <= ptt_pkg::PRIO_MAX; q++) begin
          for (int i = 0; i < model_count; i++) begin
            if (n < MAX_RESULTS && !model_done[i] && model_prios[i] == PRIO_W'(q)) begin
              if (n > 0) queue_expected(held);
              held = make_outcome(ptt_pkg::STATUS_OK, model_tags[i], model_prios[i], 1'b0);
              n++;
            end
          end
        end
        if (n == 0) begin
          queue_expected(make_outcome(ptt_pkg::STATUS_NONE, '0, '0, 1'b1));
        end else begin
          held.last = 1'b1;
          queue_expected(held);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("error at cycle %0d: %s, got %0h, expected %0h", cycles_run, what, got, want);
    error_count++;
  endtask

  always @(negedge clk) begin
    command_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        func <= nxt.func;
        task_tag <= nxt.tag;
        task_priority <= nxt.prio;
        start <= 1'b1;
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
          gap_left <= 0;
        end else begin
          gap_left <= $urandom_range(0, 6);
          if ($urandom_range(0, 11) == 0) burst_left <= $urandom_range(5, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    table_outcome_t want;
    command_t       cmd;
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst) begin
      took <= 1'b0;
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          report_error("result with nothing outstanding", {30'd0, status}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            report_error("status", 32'(status), 32'(want.status));
          end
          if (out_tag !== want.tag) begin
            report_error("out_tag", 32'(out_tag), 32'(want.tag));
          end
          if (out_priority !== want.prio) begin
            report_error("out_priority", 32'(out_priority), 32'(want.prio));
          end
          if (last !== want.last) begin
            report_error("last", 32'(last), 32'(want.last));
          end
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        cmd.func = func;
        cmd.tag = task_tag;
        cmd.prio = task_priority;
        predict_table_results(cmd);
        items_accepted <= items_accepted + 1;
      end
    end
  end

  initial begin
    int adds_queued;
    int pick;

    // Empty table, undefined operation, additions at the field extremes, then a list.
    queue_command(ptt_pkg::FUNC_EXEC, 16'hFFFF, 4'hF);
    queue_command(ptt_pkg::FUNC_LIST, 16'h0000, 4'h0);
    queue_command(FUNC_UNUSED, 16'hA5A5, 4'h5);
    queue_command(ptt_pkg::FUNC_ADD, 16'h0000, 4'd0);
    queue_command(ptt_pkg::FUNC_ADD, 16'hFFFF, 4'd15);
    queue_command(ptt_pkg::FUNC_ADD, 16'h1234, ptt_pkg::PRIO_MAX);
    queue_command(ptt_pkg::FUNC_ADD, 16'h5678, ptt_pkg::PRIO_MIN);
    queue_command(ptt_pkg::FUNC_ADD, 16'h9ABC, 4'd11);
    queue_command(ptt_pkg::FUNC_ADD, 16'h0F0F, 4'd5);
    queue_command(ptt_pkg::FUNC_ADD, 16'hF0F0, 4'd5);
    queue_command(ptt_pkg::FUNC_LIST, 16'hFFFF, 4'hF);
    adds_queued = 7;

    // Fill the table without executing, so that a full list and a full add are seen.
    while (adds_queued < TABLE_DEPTH) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_command(ptt_pkg::FUNC_ADD, TAG_W'($urandom_range(0, 65535)), random_prio());
        adds_queued++;
      end else if (pick < 9) begin
        queue_command(ptt_pkg::FUNC_LIST, TAG_W'($urandom_range(0, 65535)), random_prio());
      end else begin
        queue_command(FUNC_UNUSED, TAG_W'($urandom_range(0, 65535)), random_prio());
      end
    end
    queue_command(ptt_pkg::FUNC_LIST, 16'h0000, 4'h0);
    queue_command(ptt_pkg::FUNC_ADD, 16'hBEEF, 4'd3);

    // Drain the table by executes, interleaved with lists and further additions.
    for (int k = 0; k < 130; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        queue_command(ptt_pkg::FUNC_EXEC, TAG_W'($urandom_range(0, 65535)), random_prio());
      end else if (pick < 14) begin
        queue_command(ptt_pkg::FUNC_LIST, TAG_W'($urandom_range(0, 65535)), random_prio());
      end else if (pick < 18) begin
        queue_command(ptt_pkg::FUNC_ADD, TAG_W'($urandom_range(0, 65535)), random_prio());
      end else begin
        queue_command(FUNC_UNUSED, TAG_W'($urandom_range(0, 65535)), random_prio());
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_accepted != items_total || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
